/* rtl/adc_sss_pkg.sv */
// ----------------------------------------------------------------------------
// adc_sss_pkg
// Types, codes and constants shared by the sensor scan sequencer files.
// ----------------------------------------------------------------------------
package adc_sss_pkg;

    localparam int NUM_SENSORS = 6;
    localparam int IDX_W       = 3;
    localparam int CH_W        = 3;
    localparam int CNT_W       = 2;
    localparam int SAMPLE_W    = 8;
    localparam int OP_W        = 2;

    typedef logic [IDX_W-1:0]    t_index;
    typedef logic [CH_W-1:0]     t_chan;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [SAMPLE_W-1:0] t_sample;

    typedef t_chan t_map [NUM_SENSORS];

    localparam t_index LAST_SENSOR  = t_index'(NUM_SENSORS - 1);
    localparam int     HALF_RING    = NUM_SENSORS / 2;
    localparam t_count STORE_SWEEP  = t_count'(3);
    localparam t_count SWITCH_SWEEP = t_count'(2);

    // channel per sensor: FR, FL, L, BL, BR, R
    localparam t_map RESET_MAP = '{3'd1, 3'd0, 3'd4, 3'd2, 3'd3, 3'd5};

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_CONV   = 2'd1,
        OP_SWITCH = 2'd2
    } t_opcode;

    typedef struct packed {
        t_chan   mux_channel;
        logic    store_valid;
        t_index  store_sensor;
        t_sample store_value;
        logic    sweep_done;
    } t_result;

endpackage

/* rtl/adc_sss_in_if.sv */
// ----------------------------------------------------------------------------
// adc_sss_in_if
// Command word channel: opcode and converter sample.
// ----------------------------------------------------------------------------
interface adc_sss_in_if import adc_sss_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);

endinterface

/* rtl/adc_sss_out_if.sv */
// ----------------------------------------------------------------------------
// adc_sss_out_if
// Result word channel: next mux channel, store strobe and sweep event.
// ----------------------------------------------------------------------------
interface adc_sss_out_if import adc_sss_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CH_W-1:0]     mux_channel;
    logic                store_valid;
    logic [IDX_W-1:0]    store_sensor;
    logic [SAMPLE_W-1:0] store_value;
    logic                sweep_done;

    modport source (
        output valid, output mux_channel, output store_valid,
        output store_sensor, output store_value, output sweep_done,
        input ready
    );
    modport sink (
        input valid, input mux_channel, input store_valid,
        input store_sensor, input store_value, input sweep_done,
        output ready
    );

endinterface

/* rtl/adc_sensor_scan_sequencer.sv */
// ----------------------------------------------------------------------------
// adc_sensor_scan_sequencer
// Round-robin scan sequencer for six proximity sensors.
//
//   channel  dir  words carried
//   -------  ---  -----------------------------------------------------------
//   i_cmd    in   opcode, sample
//   o_res    out  mux_channel, store_valid, store_sensor, store_value,
//                 sweep_done
//
// One word per cycle sustained while results are taken; a word goes from the
// input register to the result register, with the state update between them.
// Synchronous active-low reset restores the channel map, index and count.
// A stalled result holds in the output register while the next command
// waits in the input register; new commands stop only when both are full.
// ----------------------------------------------------------------------------
module adc_sensor_scan_sequencer import adc_sss_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    adc_sss_in_if.sink   i_cmd,
    adc_sss_out_if.source o_res
);

    logic            r_in_valid;
    logic [OP_W-1:0] r_opcode;
    t_sample         r_sample;

    logic    r_out_valid;
    t_result r_result;

    logic    w_move;
    t_result w_result;

    assign w_move      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_opcode <= i_cmd.opcode;
            r_sample <= i_cmd.sample;
        end
    end

    adc_sss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_move),
        .i_opcode (t_opcode'(r_opcode)),
        .i_sample (r_sample),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_result <= w_result;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.mux_channel  = r_result.mux_channel;
    assign o_res.store_valid  = r_result.store_valid;
    assign o_res.store_sensor = r_result.store_sensor;
    assign o_res.store_value  = r_result.store_value;
    assign o_res.sweep_done   = r_result.sweep_done;

endmodule

/* rtl/adc_sss_core.sv */
// ----------------------------------------------------------------------------
// adc_sss_core
// Scan state (channel map, sensor index, sweep count) and per-word update.
// ----------------------------------------------------------------------------
module adc_sss_core import adc_sss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_opcode i_opcode,
    input  t_sample i_sample,
    output t_result o_result
);

    t_map   r_map;
    t_index r_index;
    t_count r_count;

    t_map   n_map;
    t_index n_index;
    t_count n_count;

    t_index w_cur;
    t_index w_next_safe;

    always_comb begin
        w_cur = (r_index < t_index'(NUM_SENSORS)) ? r_index : '0;

        n_map    = r_map;
        n_index  = r_index;
        n_count  = r_count;
        o_result = '0;

        case (i_opcode)
            OP_START: begin
                n_index = '0;
                n_count = '0;
            end
            OP_CONV: begin
                if (r_count == STORE_SWEEP) begin
                    o_result.store_valid  = 1'b1;
                    o_result.store_sensor = w_cur;
                    o_result.store_value  = i_sample;
                end
                if (w_cur == LAST_SENSOR) begin
                    n_count = r_count + t_count'(1);
                    o_result.sweep_done = (r_count == STORE_SWEEP);
                    n_index = '0;
                end else begin
                    n_index = w_cur + t_index'(1);
                end
            end
            OP_SWITCH: begin
                for (int i = 0; i < HALF_RING; i++) begin
                    n_map[i]             = r_map[i + HALF_RING];
                    n_map[i + HALF_RING] = r_map[i];
                end
                n_index = (w_cur < t_index'(HALF_RING)) ? w_cur + t_index'(HALF_RING)
                                                         : w_cur - t_index'(HALF_RING);
                n_count = SWITCH_SWEEP;
            end
            default: begin
            end
        endcase

        w_next_safe          = (n_index < t_index'(NUM_SENSORS)) ? n_index : '0;
        o_result.mux_channel = n_map[w_next_safe];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= RESET_MAP;
            r_index <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_map   <= n_map;
            r_index <= n_index;
            r_count <= n_count;
        end
    end

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index < t_index'(NUM_SENSORS))
        else $error("sensor index out of range");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_opcode == OP_START |=> r_index == '0 && r_count == '0)
        else $error("start did not clear scan state");

    a_switch_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_opcode == OP_SWITCH |=> r_count == SWITCH_SWEEP)
        else $error("switch did not set sweep count");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.sweep_done
            |-> o_result.store_valid && o_result.store_sensor == LAST_SENSOR)
        else $error("sweep done without store of last sensor");

    a_done_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.sweep_done |=> r_count == '0 && r_index == '0)
        else $error("sweep done did not wrap count and index");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor scan sequencer. A behavioral copy of the
// scan state (channel map, sensor index, sweep count) predicts every result
// word from each accepted command word; a checker compares results in order.
// Directed words cover reset state, every opcode, the unused opcode, the
// fourth-sweep store, the readings-ready event and double mirroring. Random
// bursts (start, switch, the unused opcode or none, followed by conversion
// runs) follow under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import adc_sss_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SWEEPS_PER_SET = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_CAP      = 40;
    localparam int TAIL_CYCLES    = 8;
    localparam int PHASE_WORDS    = 388;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    adc_sss_in_if  cmd_if ();
    adc_sss_out_if res_if ();

    adc_sensor_scan_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_chan   chan_map [NUM_SENSORS];
    t_index  cur_sensor;
    t_count  sweep_cnt;
    t_result pending_q [$];

    int err_cnt        = 0;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // scan state update for one accepted command word
    task automatic scan_step(input logic [OP_W-1:0] op, input t_sample smp,
                             output t_result r);
        t_index cur;
        int     cnt;
        t_chan  tmp;
        r   = '0;
        cur = (cur_sensor < NUM_SENSORS) ? cur_sensor : '0;
        case (op)
            OP_START: begin
                cur_sensor = '0;
                sweep_cnt  = '0;
            end
            OP_CONV: begin
                cnt = int'(sweep_cnt);
                if (sweep_cnt == STORE_SWEEP) begin
                    r.store_valid  = 1'b1;
                    r.store_sensor = cur;
                    r.store_value  = smp;
                end
                if (cur == LAST_SENSOR) begin
                    cnt++;
                    if (cnt == SWEEPS_PER_SET) begin
                        r.sweep_done = 1'b1;
                        cnt = 0;
                    end
                end
                sweep_cnt  = t_count'(cnt);
                cur_sensor = (cur == LAST_SENSOR) ? t_index'(0) : t_index'(cur + 1);
            end
            OP_SWITCH: begin
                for (int i = 0; i < HALF_RING; i++) begin
                    tmp                   = chan_map[i];
                    chan_map[i]           = chan_map[i + HALF_RING];
                    chan_map[i + HALF_RING] = tmp;
                end
                cur_sensor = t_index'((cur + HALF_RING) % NUM_SENSORS);
                sweep_cnt  = SWITCH_SWEEP;
            end
            default: ;
        endcase
        r.mux_channel = chan_map[(cur_sensor < NUM_SENSORS) ? cur_sensor : t_index'(0)];
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                   input logic [7:0] got_v);
        err_cnt++;
        if (err_cnt <= PRINT_CAP)
            $display("MISMATCH %s: expected %0h, got %0h (cycle %0d)",
                     what, exp_v, got_v, cycle_cnt);
    endtask

    task automatic check_result();
        t_result e;
        if (pending_q.size() == 0) begin
            report_mismatch("unexpected result word", 8'h00, 8'h00);
            return;
        end
        e = pending_q.pop_front();
        if (res_if.mux_channel !== e.mux_channel)
            report_mismatch("mux_channel", 8'(e.mux_channel), 8'(res_if.mux_channel));
        if (res_if.store_valid !== e.store_valid)
            report_mismatch("store_valid", 8'(e.store_valid), 8'(res_if.store_valid));
        if (res_if.store_sensor !== e.store_sensor)
            report_mismatch("store_sensor", 8'(e.store_sensor), 8'(res_if.store_sensor));
        if (res_if.store_value !== e.store_value)
            report_mismatch("store_value", e.store_value, res_if.store_value);
        if (res_if.sweep_done !== e.sweep_done)
            report_mismatch("sweep_done", 8'(e.sweep_done), 8'(res_if.sweep_done));
    endtask

    // result side: sample pre-edge values, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            check_result();
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input t_sample smp);
        t_result r;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.opcode <= op;
        cmd_if.sample <= smp;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        scan_step(op, smp, r);
        pending_q.push_back(r);
    endtask

    task automatic wait_results_drained();
        cmd_if.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_opcodes_from_reset();
        send_word(OP_CONV,   8'hFF);
        send_word(OP_UNUSED, 8'h00);
        send_word(OP_START,  8'hAA);
        send_word(OP_CONV,   8'h00);
        send_word(OP_SWITCH, 8'h55);
    endtask

    // switch leaves count at 2, so nine conversions reach the store sweep
    // and the readings-ready event
    task automatic test_fourth_sweep_store();
        t_sample vals [9] = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'hFF};
        send_word(OP_START,  8'h00);
        send_word(OP_SWITCH, 8'hFF);
        foreach (vals[i])
            send_word(OP_CONV, vals[i]);
    endtask

    task automatic test_mirror_twice();
        send_word(OP_SWITCH, 8'h0F);
        send_word(OP_SWITCH, 8'hF0);
        send_word(OP_CONV,   8'h3C);
        send_word(OP_UNUSED, 8'hC3);
        send_word(OP_START,  8'h5A);
    endtask

    task automatic test_burst_traffic(input int idle_pct, input int stall_pct);
        int sent;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                send_word(OP_SWITCH, t_sample'($urandom));
                sent++;
            end else if (pick < 85) begin
                send_word(OP_START, t_sample'($urandom));
                sent++;
            end else if (pick < 93) begin
                send_word(OP_UNUSED, t_sample'($urandom));
            end
            repeat ($urandom_range(1, 30)) begin
                send_word(OP_CONV, t_sample'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        cmd_if.valid  = 1'b0;
        cmd_if.opcode = '0;
        cmd_if.sample = '0;
        res_if.ready  = 1'b0;
        for (int i = 0; i < NUM_SENSORS; i++)
            chan_map[i] = RESET_MAP[i];
        cur_sensor = '0;
        sweep_cnt  = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_opcodes_from_reset();
        test_fourth_sweep_store();
        test_mirror_twice();
        wait_results_drained();

        test_burst_traffic(0, 0);
        wait_results_drained();
        test_burst_traffic(76, 0);
        wait_results_drained();
        test_burst_traffic(0, 76);
        wait_results_drained();
        test_burst_traffic(24, 24);
        wait_results_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/adc_sss_pkg.sv
rtl/adc_sss_in_if.sv
rtl/adc_sss_out_if.sv
rtl/adc_sss_core.sv
rtl/adc_sensor_scan_sequencer.sv
tb/sv/tb_top.sv
